/* sv/abk_pkg.sv */
`default_nettype none
package abk_pkg;

  localparam int COV_WIDTH = 48;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_PERIOD   = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE    = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MEASURE_NOISE = 8'd3;

  localparam logic [23:0] STEP_PERIOD_RST   = 24'd67109;
  localparam logic [23:0] ANGLE_NOISE_RST   = 24'd16777;
  localparam logic [23:0] BIAS_NOISE_RST    = 24'd50332;
  localparam logic [23:0] MEASURE_NOISE_RST = 24'd503316;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  localparam logic [1:0] SH_16 = 2'd0;
  localparam logic [1:0] SH_24 = 2'd1;
  localparam logic [1:0] SH_32 = 2'd2;

  typedef struct packed {
    logic       start;
    logic       op;
    logic [1:0] shift;
  } unit_cmd_t;

endpackage
`default_nettype wire

/* sv/abk_serial_unit.sv */
`default_nettype none
module abk_serial_unit #(
  parameter int CW = abk_pkg::COV_WIDTH
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire abk_pkg::unit_cmd_t cmd,
  input  wire logic signed [CW-1:0] op_a,
  input  wire logic signed [CW-1:0] op_b,
  output logic                   done,
  output logic signed [CW-1:0]   res
);

  localparam int PW   = 2 * CW;
  localparam int DW   = CW + 32;
  localparam int CNTW = $clog2(DW + 1);

  localparam logic [1:0] U_IDLE = 2'd0;
  localparam logic [1:0] U_RUN  = 2'd1;
  localparam logic [1:0] U_FIN  = 2'd2;

  localparam logic [1:0] SH_SEL_16 = abk_pkg::SH_16;
  localparam logic [1:0] SH_SEL_24 = abk_pkg::SH_24;

  logic [1:0]           ust_r, ust_nxt;
  logic                 div_r, div_nxt;
  logic                 neg_r, neg_nxt;
  logic [1:0]           sh_r, sh_nxt;
  logic [CNTW-1:0]      cnt_r, cnt_nxt;
  logic [CW-1:0]        mcand_r, mcand_nxt;
  logic [PW-1:0]        prod_r, prod_nxt;
  logic [CW:0]          rem_r, rem_nxt;
  logic                 done_r, done_nxt;
  logic signed [CW-1:0] res_r, res_nxt;

  logic [CW-1:0] mag_a, mag_b;
  logic [CW:0]   msum, tr;
  logic          ge;
  logic [5:0]    shamt;
  logic [PW:0]   rnd, mag, top, mc;

  assign mag_a = op_a[CW-1] ? CW'(-op_a) : CW'(op_a);
  assign mag_b = op_b[CW-1] ? CW'(-op_b) : CW'(op_b);

  always_comb begin
    ust_nxt   = ust_r;
    div_nxt   = div_r;
    neg_nxt   = neg_r;
    sh_nxt    = sh_r;
    cnt_nxt   = cnt_r;
    mcand_nxt = mcand_r;
    prod_nxt  = prod_r;
    rem_nxt   = rem_r;
    done_nxt  = 1'b0;
    res_nxt   = res_r;

    msum = {1'b0, prod_r[PW-1:CW]} + (prod_r[0] ? {1'b0, mcand_r} : '0);
    tr   = {rem_r[CW-1:0], prod_r[DW-1]};
    ge   = tr >= {1'b0, mcand_r};

    case (sh_r)
      SH_SEL_16: shamt = 6'd16;
      SH_SEL_24: shamt = 6'd24;
      default:   shamt = 6'd32;
    endcase
    rnd = {1'b0, prod_r} + ((PW+1)'(1) << (shamt - 6'd1));
    if (div_r) begin
      mag = (PW+1)'(prod_r[DW-1:0]);
    end else begin
      mag = rnd >> shamt;
    end
    top = (PW+1)'(1) << (CW - 1);
    if (neg_r) begin
      mc = (mag > top) ? top : mag;
    end else begin
      mc = (mag > top - (PW+1)'(1)) ? top - (PW+1)'(1) : mag;
    end

    case (ust_r)
      U_IDLE: begin
        if (cmd.start) begin
          ust_nxt = U_RUN;
          div_nxt = cmd.op;
          sh_nxt  = cmd.shift;
          rem_nxt = '0;
          if (cmd.op == abk_pkg::OP_DIV) begin
            neg_nxt   = op_a[CW-1];
            mcand_nxt = mag_b;
            prod_nxt  = PW'({mag_a, 32'd0});
            cnt_nxt   = CNTW'(DW - 1);
          end else begin
            neg_nxt   = op_a[CW-1] ^ op_b[CW-1];
            mcand_nxt = mag_a;
            prod_nxt  = PW'(mag_b);
            cnt_nxt   = CNTW'(CW - 1);
          end
        end
      end
      U_RUN: begin
        if (div_r) begin
          rem_nxt  = ge ? tr - {1'b0, mcand_r} : tr;
          prod_nxt = PW'({prod_r[DW-2:0], ge});
        end else begin
          prod_nxt = {msum, prod_r[CW-1:1]};
        end
        cnt_nxt = cnt_r - CNTW'(1);
        if (cnt_r == '0) begin
          ust_nxt = U_FIN;
        end
      end
      U_FIN: begin
        res_nxt  = neg_r ? signed'(CW'(-mc)) : signed'(CW'(mc));
        done_nxt = 1'b1;
        ust_nxt  = U_IDLE;
      end
      default: begin
        ust_nxt = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ust_r  <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      ust_r  <= ust_nxt;
      done_r <= done_nxt;
    end
    div_r   <= div_nxt;
    neg_r   <= neg_nxt;
    sh_r    <= sh_nxt;
    cnt_r   <= cnt_nxt;
    mcand_r <= mcand_nxt;
    prod_r  <= prod_nxt;
    rem_r   <= rem_nxt;
    res_r   <= res_nxt;
  end

  assign done = done_r;
  assign res  = res_r;

  a_done_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(ust_r) == U_FIN)
    else $error("unit done without finishing pass");
  a_start_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
    (ust_r == U_RUN && cnt_r != '0) |=> ust_r == U_RUN)
    else $error("unit left iteration early");
  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (ust_r == U_RUN && div_r) |-> rem_r < {1'b0, mcand_r} || mcand_r == '0)
    else $error("partial remainder not below divisor");

endmodule
`default_nettype wire

/* sv/angle_bias_kalman_filter.sv */
`default_nettype none
// Two-state angle/gyro-bias Kalman filter. Each accepted item (measured angle signed Q9.16, gyro
// rate signed Q12.16) runs the predict and update steps and yields one item with the new angle and
// bias. All multiplies and the two gain divisions run on one shared shift-add/restore unit, one
// bit per cycle. An item takes ten multiplies, two divisions, seven add steps and a result step;
// the result appears in the same cycle as the input is freed for the next item. When the
// innovation variance is not positive both divisions are skipped, and a result held by out_stall
// adds the time it waits. The input is stalled from acceptance until the result is loaded.
// The user must write registers through the cfg port only while idle; the block does not
// enforce this.
module angle_bias_kalman_filter #(
  parameter int COVARIANCE_WIDTH = abk_pkg::COV_WIDTH
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire logic signed [24:0] in_measured_angle,
  input  wire logic signed [27:0] in_gyro_rate,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic signed [31:0]  out_angle_estimate,
  output logic signed [31:0]  out_bias_estimate,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire logic [abk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [23:0]    cfg_data
);

  localparam int CW = COVARIANCE_WIDTH;
  localparam int XW = CW + 2;

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_M_RATE = 5'd1;
  localparam logic [4:0] ST_M_DTP  = 5'd2;
  localparam logic [4:0] ST_A_T1   = 5'd3;
  localparam logic [4:0] ST_A_T2   = 5'd4;
  localparam logic [4:0] ST_A_T3   = 5'd5;
  localparam logic [4:0] ST_M_AA   = 5'd6;
  localparam logic [4:0] ST_A_AB   = 5'd7;
  localparam logic [4:0] ST_A_BA   = 5'd8;
  localparam logic [4:0] ST_M_BB   = 5'd9;
  localparam logic [4:0] ST_A_S    = 5'd10;
  localparam logic [4:0] ST_D_K0   = 5'd11;
  localparam logic [4:0] ST_D_K1   = 5'd12;
  localparam logic [4:0] ST_A_Y    = 5'd13;
  localparam logic [4:0] ST_M_ANG  = 5'd14;
  localparam logic [4:0] ST_M_BIAS = 5'd15;
  localparam logic [4:0] ST_U_BA   = 5'd16;
  localparam logic [4:0] ST_U_BB   = 5'd17;
  localparam logic [4:0] ST_U_AA   = 5'd18;
  localparam logic [4:0] ST_U_AB   = 5'd19;
  localparam logic [4:0] ST_DONE   = 5'd20;

  function automatic logic signed [XW-1:0] clampw(input logic signed [XW-1:0] v, input int w);
    logic signed [XW-1:0] mx;
    logic signed [XW-1:0] mn;
    mx = signed'((XW'(1) << (w - 1)) - XW'(1));
    mn = ~mx;
    if (v > mx) begin
      clampw = mx;
    end else if (v < mn) begin
      clampw = mn;
    end else begin
      clampw = v;
    end
  endfunction

  logic [4:0]           st_r, st_nxt;
  logic                 pend_r, pend_nxt;
  logic [23:0]          step_period_r, angle_noise_r, bias_noise_r, measure_noise_r;
  logic signed [24:0]   meas_r, meas_nxt;
  logic signed [27:0]   rate_r, rate_nxt;
  logic signed [31:0]   ang_r, ang_nxt, bias_r, bias_nxt;
  logic signed [CW-1:0] caa_r, caa_nxt, cab_r, cab_nxt, cba_r, cba_nxt, cbb_r, cbb_nxt;
  logic signed [CW-1:0] t_r, t_nxt, dtp_r, dtp_nxt, s_r, s_nxt;
  logic signed [CW-1:0] k0_r, k0_nxt, k1_r, k1_nxt;
  logic signed [32:0]   y_r, y_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic signed [31:0]   out_ang_r, out_ang_nxt, out_bias_r, out_bias_nxt;

  abk_pkg::unit_cmd_t   ucmd;
  logic signed [CW-1:0] u_a, u_b, u_res;
  logic                 u_done, u_state;
  logic signed [XW-1:0] add_a, add_b, add_sum, add_sat;
  logic                 add_sub, add_narrow;
  logic signed [CW-1:0] dt_s, qb_s;
  logic signed [32:0]   rdiff;
  logic signed [XW-1:0] qa8, r8;

  assign dt_s  = signed'(CW'(step_period_r));
  assign qb_s  = signed'(CW'(bias_noise_r));
  assign qa8   = signed'(XW'({angle_noise_r, 8'd0}));
  assign r8    = signed'(XW'({measure_noise_r, 8'd0}));
  assign rdiff = 33'(rate_r) - 33'(bias_r);

  always_comb begin
    u_state = 1'b1;
    u_a = dt_s;
    u_b = cbb_r;
    ucmd.op = abk_pkg::OP_MUL;
    ucmd.shift = abk_pkg::SH_24;
    case (st_r)
      ST_M_RATE: u_b = CW'(rdiff);
      ST_M_DTP:  u_b = cbb_r;
      ST_M_AA:   u_b = t_r;
      ST_M_BB: begin
        u_a = qb_s;
        u_b = dt_s;
        ucmd.shift = abk_pkg::SH_16;
      end
      ST_D_K0: begin
        u_a = caa_r;
        u_b = s_r;
        ucmd.op = abk_pkg::OP_DIV;
      end
      ST_D_K1: begin
        u_a = cba_r;
        u_b = s_r;
        ucmd.op = abk_pkg::OP_DIV;
      end
      ST_M_ANG: begin
        u_a = k0_r;
        u_b = CW'(y_r);
        ucmd.shift = abk_pkg::SH_32;
      end
      ST_M_BIAS: begin
        u_a = k1_r;
        u_b = CW'(y_r);
        ucmd.shift = abk_pkg::SH_32;
      end
      ST_U_BA: begin
        u_a = k1_r;
        u_b = caa_r;
        ucmd.shift = abk_pkg::SH_32;
      end
      ST_U_BB: begin
        u_a = k1_r;
        u_b = cab_r;
        ucmd.shift = abk_pkg::SH_32;
      end
      ST_U_AA: begin
        u_a = k0_r;
        u_b = caa_r;
        ucmd.shift = abk_pkg::SH_32;
      end
      ST_U_AB: begin
        u_a = k0_r;
        u_b = cab_r;
        ucmd.shift = abk_pkg::SH_32;
      end
      default: u_state = 1'b0;
    endcase
    ucmd.start = u_state && !pend_r;
  end

  abk_serial_unit #(.CW(CW)) u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (ucmd),
    .op_a (u_a),
    .op_b (u_b),
    .done (u_done),
    .res  (u_res)
  );

  // shared saturating adder
  always_comb begin
    add_a = XW'(caa_r);
    add_b = XW'(u_res);
    add_sub = 1'b0;
    add_narrow = 1'b0;
    case (st_r)
      ST_M_RATE, ST_M_ANG: begin
        add_a = XW'(ang_r);
        add_narrow = 1'b1;
      end
      ST_M_BIAS: begin
        add_a = XW'(bias_r);
        add_narrow = 1'b1;
      end
      ST_A_T1: begin
        add_a = XW'(dtp_r);
        add_b = XW'(cab_r);
        add_sub = 1'b1;
      end
      ST_A_T2: begin
        add_a = XW'(t_r);
        add_b = XW'(cba_r);
        add_sub = 1'b1;
      end
      ST_A_T3: begin
        add_a = XW'(t_r);
        add_b = qa8;
      end
      ST_M_AA: add_a = XW'(caa_r);
      ST_A_AB: begin
        add_a = XW'(cab_r);
        add_b = XW'(dtp_r);
        add_sub = 1'b1;
      end
      ST_A_BA: begin
        add_a = XW'(cba_r);
        add_b = XW'(dtp_r);
        add_sub = 1'b1;
      end
      ST_M_BB: add_a = XW'(cbb_r);
      ST_A_S:  add_b = r8;
      ST_U_BA: begin
        add_a = XW'(cba_r);
        add_sub = 1'b1;
      end
      ST_U_BB: begin
        add_a = XW'(cbb_r);
        add_sub = 1'b1;
      end
      ST_U_AA: add_sub = 1'b1;
      ST_U_AB: begin
        add_a = XW'(cab_r);
        add_sub = 1'b1;
      end
      default: add_sub = 1'b0;
    endcase
    add_sum = add_sub ? add_a - add_b : add_a + add_b;
    add_sat = clampw(add_sum, add_narrow ? 32 : CW);
  end

  always_comb begin
    st_nxt = st_r;
    pend_nxt = pend_r;
    meas_nxt = meas_r;
    rate_nxt = rate_r;
    ang_nxt = ang_r;
    bias_nxt = bias_r;
    caa_nxt = caa_r;
    cab_nxt = cab_r;
    cba_nxt = cba_r;
    cbb_nxt = cbb_r;
    t_nxt = t_r;
    dtp_nxt = dtp_r;
    s_nxt = s_r;
    k0_nxt = k0_r;
    k1_nxt = k1_r;
    y_nxt = y_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ang_nxt = out_ang_r;
    out_bias_nxt = out_bias_r;

    if (ucmd.start) begin
      pend_nxt = 1'b1;
    end
    if (u_done) begin
      pend_nxt = 1'b0;
    end

    case (st_r)
      ST_IDLE: begin
        if (in_valid) begin
          meas_nxt = in_measured_angle;
          rate_nxt = in_gyro_rate;
          st_nxt = ST_M_RATE;
        end
      end
      ST_M_RATE: begin
        if (u_done) begin
          ang_nxt = add_sat[31:0];
          st_nxt = ST_M_DTP;
        end
      end
      ST_M_DTP: begin
        if (u_done) begin
          dtp_nxt = u_res;
          st_nxt = ST_A_T1;
        end
      end
      ST_A_T1: begin
        t_nxt = add_sat[CW-1:0];
        st_nxt = ST_A_T2;
      end
      ST_A_T2: begin
        t_nxt = add_sat[CW-1:0];
        st_nxt = ST_A_T3;
      end
      ST_A_T3: begin
        t_nxt = add_sat[CW-1:0];
        st_nxt = ST_M_AA;
      end
      ST_M_AA: begin
        if (u_done) begin
          caa_nxt = add_sat[CW-1:0];
          st_nxt = ST_A_AB;
        end
      end
      ST_A_AB: begin
        cab_nxt = add_sat[CW-1:0];
        st_nxt = ST_A_BA;
      end
      ST_A_BA: begin
        cba_nxt = add_sat[CW-1:0];
        st_nxt = ST_M_BB;
      end
      ST_M_BB: begin
        if (u_done) begin
          cbb_nxt = add_sat[CW-1:0];
          st_nxt = ST_A_S;
        end
      end
      ST_A_S: begin
        s_nxt = add_sat[CW-1:0];
        if (add_sat > 0) begin
          st_nxt = ST_D_K0;
        end else begin
          k0_nxt = '0;
          k1_nxt = '0;
          st_nxt = ST_A_Y;
        end
      end
      ST_D_K0: begin
        if (u_done) begin
          k0_nxt = u_res;
          st_nxt = ST_D_K1;
        end
      end
      ST_D_K1: begin
        if (u_done) begin
          k1_nxt = u_res;
          st_nxt = ST_A_Y;
        end
      end
      ST_A_Y: begin
        y_nxt = 33'(meas_r) - 33'(ang_r);
        st_nxt = ST_M_ANG;
      end
      ST_M_ANG: begin
        if (u_done) begin
          ang_nxt = add_sat[31:0];
          st_nxt = ST_M_BIAS;
        end
      end
      ST_M_BIAS: begin
        if (u_done) begin
          bias_nxt = add_sat[31:0];
          st_nxt = ST_U_BA;
        end
      end
      ST_U_BA: begin
        if (u_done) begin
          cba_nxt = add_sat[CW-1:0];
          st_nxt = ST_U_BB;
        end
      end
      ST_U_BB: begin
        if (u_done) begin
          cbb_nxt = add_sat[CW-1:0];
          st_nxt = ST_U_AA;
        end
      end
      ST_U_AA: begin
        if (u_done) begin
          caa_nxt = add_sat[CW-1:0];
          st_nxt = ST_U_AB;
        end
      end
      ST_U_AB: begin
        if (u_done) begin
          cab_nxt = add_sat[CW-1:0];
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!(out_valid_r && out_stall)) begin
          out_valid_nxt = 1'b1;
          out_ang_nxt = ang_r;
          out_bias_nxt = bias_r;
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      pend_r <= 1'b0;
      out_valid_r <= 1'b0;
      step_period_r <= abk_pkg::STEP_PERIOD_RST;
      angle_noise_r <= abk_pkg::ANGLE_NOISE_RST;
      bias_noise_r <= abk_pkg::BIAS_NOISE_RST;
      measure_noise_r <= abk_pkg::MEASURE_NOISE_RST;
      ang_r <= '0;
      bias_r <= '0;
      caa_r <= '0;
      cab_r <= '0;
      cba_r <= '0;
      cbb_r <= '0;
    end else begin
      st_r <= st_nxt;
      pend_r <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      ang_r <= ang_nxt;
      bias_r <= bias_nxt;
      caa_r <= caa_nxt;
      cab_r <= cab_nxt;
      cba_r <= cba_nxt;
      cbb_r <= cbb_nxt;
      if (cfg_valid) begin
        case (cfg_index)
          abk_pkg::REG_STEP_PERIOD:   step_period_r <= cfg_data;
          abk_pkg::REG_ANGLE_NOISE:   angle_noise_r <= cfg_data;
          abk_pkg::REG_BIAS_NOISE:    bias_noise_r <= cfg_data;
          abk_pkg::REG_MEASURE_NOISE: measure_noise_r <= cfg_data;
          default: ;
        endcase
      end
    end
    meas_r <= meas_nxt;
    rate_r <= rate_nxt;
    t_r <= t_nxt;
    dtp_r <= dtp_nxt;
    s_r <= s_nxt;
    k0_r <= k0_nxt;
    k1_r <= k1_nxt;
    y_r <= y_nxt;
    out_ang_r <= out_ang_nxt;
    out_bias_r <= out_bias_nxt;
  end

  assign in_stall = (st_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_angle_estimate = out_ang_r;
  assign out_bias_estimate = out_bias_r;

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> st_r == ST_M_RATE)
    else $error("accepted item did not start prediction");
  a_done_pending: assert property (@(posedge clk) disable iff (!rst_n)
    u_done |-> pend_r)
    else $error("unit result with no request");
  a_gain_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_A_Y && s_r <= 0) |-> (k0_r == '0 && k1_r == '0))
    else $error("gain nonzero with nonpositive innovation variance");
  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE && !(out_valid_r && out_stall)) |=> out_valid_r && st_r == ST_IDLE)
    else $error("result not presented");

endmodule
`default_nettype wire

/* bench/tb_angle_bias_kalman_filter.sv */
`timescale 1ns / 1ps
module tb_angle_bias_kalman_filter;

  localparam int CW = abk_pkg::COV_WIDTH;

  typedef struct {
    logic signed [31:0] angle;
    logic signed [31:0] bias;
  } estimate_t;

  typedef struct {
    logic signed [24:0] angle;
    logic signed [27:0] rate;
    bit                 typed;
    logic signed [31:0] exp_angle;
    logic signed [31:0] exp_bias;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [24:0] in_measured_angle = '0;
  logic signed [27:0] in_gyro_rate = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_angle_estimate;
  logic signed [31:0] out_bias_estimate;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [abk_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  angle_bias_kalman_filter u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_measured_angle(in_measured_angle), .in_gyro_rate(in_gyro_rate),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_angle_estimate(out_angle_estimate), .out_bias_estimate(out_bias_estimate),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // filter model state
  logic [23:0] dt_reg, qa_reg, qb_reg, r_reg;
  longint angle_st, bias_st, p_aa, p_ab, p_ba, p_bb;

  estimate_t pending[$];
  int errors = 0;
  int items_sent = 0;
  bit quiet = 1'b0;

  function automatic longint clip(logic signed [127:0] v, int w);
    logic signed [127:0] mx;
    logic signed [127:0] mn;
    mx = (128'sd1 <<< (w - 1)) - 128'sd1;
    mn = -mx - 128'sd1;
    if (v > mx) return mx[63:0];
    if (v < mn) return mn[63:0];
    return v[63:0];
  endfunction

  function automatic longint sat_add(longint a, longint b, int w);
    logic signed [127:0] x, y;
    x = a;
    y = b;
    return clip(x + y, w);
  endfunction

  function automatic longint sat_sub(longint a, longint b, int w);
    logic signed [127:0] x, y;
    x = a;
    y = b;
    return clip(x - y, w);
  endfunction

  function automatic logic [127:0] mag(longint a);
    logic signed [127:0] x;
    x = a;
    return (x < 0) ? -x : x;
  endfunction

  function automatic longint sat_mag(bit neg, logic [127:0] m, int w);
    logic [127:0] top;
    logic [63:0] r;
    top = 128'd1 << (w - 1);
    if (neg) begin
      if (m > top) m = top;
      r = -m[63:0];
      return r;
    end
    if (m > top - 1) m = top - 1;
    return m[63:0];
  endfunction

  function automatic longint fx_mul(longint a, longint b, int sh, int w);
    logic [127:0] p;
    p = mag(a) * mag(b);
    if (sh > 0) p = (p + (128'd1 << (sh - 1))) >> sh;
    return sat_mag((a < 0) != (b < 0), p, w);
  endfunction

  function automatic longint fx_div(longint num, longint den, int w);
    logic [127:0] n, q;
    n = mag(num) << 32;
    q = n / mag(den);
    return sat_mag(num < 0, q, w);
  endfunction

  function automatic void filter_reset();
    dt_reg = abk_pkg::STEP_PERIOD_RST;
    qa_reg = abk_pkg::ANGLE_NOISE_RST;
    qb_reg = abk_pkg::BIAS_NOISE_RST;
    r_reg = abk_pkg::MEASURE_NOISE_RST;
    angle_st = 0; bias_st = 0;
    p_aa = 0; p_ab = 0; p_ba = 0; p_bb = 0;
  endfunction

  function automatic estimate_t filter_step(logic signed [24:0] meas_in,
                                            logic signed [27:0] rate_in);
    longint dt, rate, meas, dtp, t, s, k0, k1, y, p00, p01;
    estimate_t e;
    dt = dt_reg;
    rate = rate_in;
    meas = meas_in;
    k0 = 0; k1 = 0;
    rate = rate - bias_st;
    angle_st = sat_add(angle_st, fx_mul(dt, rate, 24, 64), 32);
    dtp = fx_mul(dt, p_bb, 24, CW);
    t = sat_sub(dtp, p_ab, CW);
    t = sat_sub(t, p_ba, CW);
    t = sat_add(t, longint'(qa_reg) <<< 8, CW);
    p_aa = sat_add(p_aa, fx_mul(dt, t, 24, CW), CW);
    p_ab = sat_sub(p_ab, dtp, CW);
    p_ba = sat_sub(p_ba, dtp, CW);
    p_bb = sat_add(p_bb, fx_mul(longint'(qb_reg), dt, 16, CW), CW);
    s = sat_add(p_aa, longint'(r_reg) <<< 8, CW);
    if (s > 0) begin
      k0 = fx_div(p_aa, s, CW);
      k1 = fx_div(p_ba, s, CW);
    end
    y = meas - angle_st;
    angle_st = sat_add(angle_st, fx_mul(k0, y, 32, 64), 32);
    bias_st = sat_add(bias_st, fx_mul(k1, y, 32, 64), 32);
    p00 = p_aa;
    p01 = p_ab;
    p_aa = sat_sub(p_aa, fx_mul(k0, p00, 32, CW), CW);
    p_ab = sat_sub(p_ab, fx_mul(k0, p01, 32, CW), CW);
    p_ba = sat_sub(p_ba, fx_mul(k1, p00, 32, CW), CW);
    p_bb = sat_sub(p_bb, fx_mul(k1, p01, 32, CW), CW);
    e.angle = angle_st[31:0];
    e.bias = bias_st[31:0];
    return e;
  endfunction

  task automatic wait_drained();
    while (pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [abk_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      abk_pkg::REG_STEP_PERIOD:   dt_reg = val;
      abk_pkg::REG_ANGLE_NOISE:   qa_reg = val;
      abk_pkg::REG_BIAS_NOISE:    qb_reg = val;
      abk_pkg::REG_MEASURE_NOISE: r_reg = val;
      default: ;
    endcase
  endtask

  task automatic send_item(stim_row_t row);
    estimate_t e;
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 16);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_measured_angle <= row.angle;
    in_gyro_rate <= row.rate;
    do @(posedge clk); while (in_stall);
    e = filter_step(row.angle, row.rate);
    if (row.typed) begin
      e.angle = row.exp_angle;
      e.bias = row.exp_bias;
    end
    pending.push_back(e);
    items_sent++;
  endtask

  function automatic stim_row_t rand_row();
    stim_row_t r;
    r.typed = 1'b0;
    r.exp_angle = '0;
    r.exp_bias = '0;
    case ($urandom_range(0, 4))
      0: r.angle = $urandom_range(0, 1) ? 25'sd11796480 : -25'sd11796480;
      1: r.angle = 25'($signed($urandom_range(0, 2 * 11796480)) - 11796480);
      default: r.angle = 25'($signed($urandom_range(0, 2 * 655360)) - 655360);
    endcase
    case ($urandom_range(0, 4))
      0: r.rate = 28'($urandom());
      1: r.rate = $urandom_range(0, 1) ? 28'sh7ffffff : 28'sh8000000;
      default: r.rate = 28'($signed($urandom_range(0, 2 * 3276800)) - 3276800);
    endcase
    return r;
  endfunction

  function automatic logic [23:0] rand_reg(logic [23:0] lo);
    case ($urandom_range(0, 3))
      0: return 24'hffffff;
      1: return lo;
      default: return 24'($urandom_range(lo, 24'h0fffff));
    endcase
  endfunction

  stim_row_t directed[] = '{
    '{25'sd0, 28'sd0, 1'b1, 32'sd0, 32'sd0},
    '{25'sd0, 28'sd0, 1'b1, 32'sd0, 32'sd0},
    '{25'sd11796480, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{-25'sd11796480, 28'sd0, 1'b0, 32'sd0, 32'sd0},
    '{25'sd0, 28'sh7ffffff, 1'b0, 32'sd0, 32'sd0},
    '{25'sd0, 28'sh8000000, 1'b0, 32'sd0, 32'sd0},
    '{25'sd11796480, 28'sh7ffffff, 1'b0, 32'sd0, 32'sd0},
    '{-25'sd11796480, 28'sh8000000, 1'b0, 32'sd0, 32'sd0},
    '{25'sd65536, 28'sd655360, 1'b0, 32'sd0, 32'sd0},
    '{-25'sd1, 28'sd1, 1'b0, 32'sd0, 32'sd0},
    '{25'sh0aaaaaa, 28'sh5555555, 1'b0, 32'sd0, 32'sd0},
    '{25'sh1555555, 28'shaaaaaaa, 1'b0, 32'sd0, 32'sd0}
  };

  initial begin
    filter_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (directed[i]) send_item(directed[i]);
    in_valid <= 1'b0;
    wait_drained();
    // zero period, zero noise, then two out-of-range indices
    write_reg(abk_pkg::REG_STEP_PERIOD, 24'd0);
    write_reg(abk_pkg::REG_ANGLE_NOISE, 24'd0);
    write_reg(abk_pkg::REG_BIAS_NOISE, 24'd0);
    write_reg(abk_pkg::REG_MEASURE_NOISE, 24'd0);
    write_reg(8'd4, 24'hffffff);
    write_reg(8'hff, 24'h123456);
    for (int i = 0; i < 4; i++) send_item(directed[2 + i]);
    in_valid <= 1'b0;
    wait_drained();
    write_reg(abk_pkg::REG_STEP_PERIOD, 24'hffffff);
    write_reg(abk_pkg::REG_ANGLE_NOISE, 24'hffffff);
    write_reg(abk_pkg::REG_BIAS_NOISE, 24'hffffff);
    write_reg(abk_pkg::REG_MEASURE_NOISE, 24'hffffff);
    for (int i = 0; i < 6; i++) send_item(directed[2 + i]);
    in_valid <= 1'b0;
    wait_drained();
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 0) begin
        write_reg(abk_pkg::REG_STEP_PERIOD, abk_pkg::STEP_PERIOD_RST);
        write_reg(abk_pkg::REG_ANGLE_NOISE, abk_pkg::ANGLE_NOISE_RST);
        write_reg(abk_pkg::REG_BIAS_NOISE, abk_pkg::BIAS_NOISE_RST);
        write_reg(abk_pkg::REG_MEASURE_NOISE, abk_pkg::MEASURE_NOISE_RST);
      end else begin
        write_reg(abk_pkg::REG_STEP_PERIOD, rand_reg(24'd1));
        write_reg(abk_pkg::REG_ANGLE_NOISE, rand_reg(24'd0));
        write_reg(abk_pkg::REG_BIAS_NOISE, rand_reg(24'd0));
        write_reg(abk_pkg::REG_MEASURE_NOISE, rand_reg(24'd1));
      end
      if (ph == 4) quiet = 1'b1;
      for (int i = 0; i < 76; i++) send_item(rand_row());
      in_valid <= 1'b0;
      wait_drained();
    end
    repeat (800) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    int n;
    wait (items_sent >= 14);
    @(posedge clk);
    out_stall <= 1'b1;
    repeat (3000) @(posedge clk);
    out_stall <= 1'b0;
    forever begin
      if (quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = $urandom_range(1, 16);
        out_stall <= ($urandom_range(0, 2) == 0);
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    estimate_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $display("%0t: unexpected item angle=%0d bias=%0d", $time,
                 out_angle_estimate, out_bias_estimate);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_angle_estimate !== e.angle) begin
          $display("%0t: angle_estimate expected %0d actual %0d", $time, e.angle,
                   out_angle_estimate);
          errors++;
        end
        if (out_bias_estimate !== e.bias) begin
          $display("%0t: bias_estimate expected %0d actual %0d", $time, e.bias,
                   out_bias_estimate);
          errors++;
        end
      end
    end
  end

  initial begin
    #40ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
